// ===== src/abkf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_pkg
// types, constants and saturation helpers of the angle/bias kalman filter
// ----------------------------------------------------------------------------
package abkf_pkg;

  // item formats
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic        [31:0] time_step;
  } abkf_in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] unbiased_rate;
  } abkf_out_t;

  // opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // register indexes
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

  // register reset values, q8.24
  localparam logic [31:0] ANGLE_NOISE_RST = 32'd20133;
  localparam logic [31:0] BIAS_NOISE_RST  = 32'd236558746;
  localparam logic [31:0] MEAS_NOISE_RST  = 32'd251658;

  // product scaling of the shared multiplier
  typedef enum logic [1:0] {
    SHIFT_16,
    SHIFT_24,
    SHIFT_32
  } shift_e;

  typedef struct packed {
    logic signed [48:0] a;
    logic signed [48:0] b;
    shift_e             shift;
    logic               wide;   // saturate to 48 bits, else to 32
  } mul_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_ANG_MUL,
    ST_ANG_ADD,
    ST_T_MUL,
    ST_INNER,
    ST_P00_MUL,
    ST_P00_ADD,
    ST_P11_MUL,
    ST_P11_ADD,
    ST_INNOV,
    ST_DIV0,
    ST_DIV1,
    ST_KA_MUL,
    ST_KA_ADD,
    ST_KB_MUL,
    ST_KB_ADD,
    ST_C00_MUL,
    ST_C00_ADD,
    ST_C01_MUL,
    ST_C01_ADD,
    ST_C10_MUL,
    ST_C10_ADD,
    ST_C11_MUL,
    ST_C11_ADD,
    ST_OUT
  } state_e;

  localparam logic signed [51:0] MAX32 = 52'sh000007FFFFFFF;
  localparam logic signed [51:0] MIN32 = 52'shFFFFF80000000;
  localparam logic signed [51:0] MAX48 = 52'sh07FFFFFFFFFFF;
  localparam logic signed [51:0] MIN48 = 52'shF800000000000;

  function automatic logic signed [51:0] ext32(input logic signed [31:0] v);
    return {{20{v[31]}}, v};
  endfunction

  function automatic logic signed [51:0] ext48(input logic signed [47:0] v);
    return {{4{v[47]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > MAX32) r = MAX32[31:0];
    else if (v < MIN32) r = MIN32[31:0];
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > MAX48) r = MAX48[47:0];
    else if (v < MIN48) r = MIN48[47:0];
    else r = v[47:0];
    return r;
  endfunction

endpackage

// ===== src/angle_bias_kalman_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// two-state kalman filter (angle, gyro bias) on one shared multiplier and
// one shared divider under a step sequencer
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (abkf_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (abkf_out_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  an update item runs ten products on the shared multiplier and two gain
//  divisions of 80 quotient bits each
//  in_stall_o is high from the accepted item until its result is registered;
//  the result register then holds it while the next item is accepted
//  reset clears the state, the covariance and the valid flag of the result register
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  abkf_pkg::abkf_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output abkf_pkg::abkf_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import abkf_pkg::*;

  state_e state_q, state_d;
  logic   issued_q;

  // configuration
  logic [31:0] qa_q, qb_q, rm_q;

  // filter state
  logic signed [31:0] angle_q, bias_q, rate_q;
  logic signed [47:0] p00_q, p01_q, p10_q, p11_q;

  // per-item working registers
  abkf_in_t           item_q;
  logic signed [47:0] t_q, inner_q, p00s_q, p01s_q, k0_q, k1_q;
  logic signed [32:0] y_q;
  logic signed [48:0] s_q;

  abkf_out_t out_q;
  logic      out_vld_q;

  // shared units
  mul_cmd_t           mul_cmd;
  logic               mul_start, mul_done;
  logic signed [47:0] mres;
  logic               div_start, div_done;
  logic signed [47:0] div_num, dres;
  logic               unit_state, out_load, in_acc;

  logic signed [48:0] dt49, rate49, y49, qb49;
  logic signed [51:0] qa52;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_OUT) && (!out_vld_q || !out_stall_i);
  assign dt49     = {17'b0, item_q.time_step};
  assign rate49   = {{17{rate_q[31]}}, rate_q};
  assign y49      = {{16{y_q[32]}}, y_q};
  assign qb49     = {17'b0, qb_q};
  assign qa52     = {12'b0, qa_q, 8'b0};

  abkf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .cmd_i   (mul_cmd),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  abkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_q),
    .done_o  (div_done),
    .res_o   (dres)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = (in_data_i.opcode == OP_LOAD) ? ST_OUT : ST_RATE;
      ST_RATE:    state_d = ST_ANG_MUL;
      ST_ANG_MUL: if (mul_done) state_d = ST_ANG_ADD;
      ST_ANG_ADD: state_d = ST_T_MUL;
      ST_T_MUL:   if (mul_done) state_d = ST_INNER;
      ST_INNER:   state_d = ST_P00_MUL;
      ST_P00_MUL: if (mul_done) state_d = ST_P00_ADD;
      ST_P00_ADD: state_d = ST_P11_MUL;
      ST_P11_MUL: if (mul_done) state_d = ST_P11_ADD;
      ST_P11_ADD: state_d = ST_INNOV;
      ST_INNOV:   state_d = ST_DIV0;
      ST_DIV0:    if (div_done) state_d = ST_DIV1;
      ST_DIV1:    if (div_done) state_d = ST_KA_MUL;
      ST_KA_MUL:  if (mul_done) state_d = ST_KA_ADD;
      ST_KA_ADD:  state_d = ST_KB_MUL;
      ST_KB_MUL:  if (mul_done) state_d = ST_KB_ADD;
      ST_KB_ADD:  state_d = ST_C00_MUL;
      ST_C00_MUL: if (mul_done) state_d = ST_C00_ADD;
      ST_C00_ADD: state_d = ST_C01_MUL;
      ST_C01_MUL: if (mul_done) state_d = ST_C01_ADD;
      ST_C01_ADD: state_d = ST_C10_MUL;
      ST_C10_MUL: if (mul_done) state_d = ST_C10_ADD;
      ST_C10_ADD: state_d = ST_C11_MUL;
      ST_C11_MUL: if (mul_done) state_d = ST_C11_ADD;
      ST_C11_ADD: state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // unit commands
  always_comb begin
    mul_cmd    = '{a: '0, b: '0, shift: SHIFT_32, wide: 1'b1};
    unit_state = 1'b1;
    div_num    = p00_q;
    unique case (state_q)
      ST_ANG_MUL: mul_cmd = '{a: dt49, b: rate49, shift: SHIFT_24, wide: 1'b0};
      ST_T_MUL:   mul_cmd = '{a: dt49, b: {p11_q[47], p11_q}, shift: SHIFT_24, wide: 1'b1};
      ST_P00_MUL: mul_cmd = '{a: dt49, b: {inner_q[47], inner_q}, shift: SHIFT_24, wide: 1'b1};
      ST_P11_MUL: mul_cmd = '{a: qb49, b: dt49, shift: SHIFT_16, wide: 1'b1};
      ST_KA_MUL:  mul_cmd = '{a: {k0_q[47], k0_q}, b: y49, shift: SHIFT_32, wide: 1'b0};
      ST_KB_MUL:  mul_cmd = '{a: {k1_q[47], k1_q}, b: y49, shift: SHIFT_32, wide: 1'b0};
      ST_C00_MUL: mul_cmd = '{a: {k0_q[47], k0_q}, b: {p00s_q[47], p00s_q},
                              shift: SHIFT_32, wide: 1'b1};
      ST_C01_MUL: mul_cmd = '{a: {k0_q[47], k0_q}, b: {p01s_q[47], p01s_q},
                              shift: SHIFT_32, wide: 1'b1};
      ST_C10_MUL: mul_cmd = '{a: {k1_q[47], k1_q}, b: {p00s_q[47], p00s_q},
                              shift: SHIFT_32, wide: 1'b1};
      ST_C11_MUL: mul_cmd = '{a: {k1_q[47], k1_q}, b: {p01s_q[47], p01s_q},
                              shift: SHIFT_32, wide: 1'b1};
      ST_DIV0:    div_num = p00_q;
      ST_DIV1:    div_num = p10_q;
      default:    unit_state = 1'b0;
    endcase
    // one start pulse on entry to a unit step
    mul_start = unit_state && !issued_q && (state_q != ST_DIV0) && (state_q != ST_DIV1);
    div_start = !issued_q && ((state_q == ST_DIV0) || (state_q == ST_DIV1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issued_q  <= 1'b0;
      out_vld_q <= 1'b0;
      qa_q      <= ANGLE_NOISE_RST;
      qb_q      <= BIAS_NOISE_RST;
      rm_q      <= MEAS_NOISE_RST;
      angle_q   <= '0;
      bias_q    <= '0;
      rate_q    <= '0;
      p00_q     <= '0;
      p01_q     <= '0;
      p10_q     <= '0;
      p11_q     <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= unit_state && !(mul_done || div_done);

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_ANGLE_NOISE: qa_q <= cfg_data_i;
          REG_BIAS_NOISE:  qb_q <= cfg_data_i;
          REG_MEAS_NOISE:  rm_q <= cfg_data_i;
          default: ;   // unused index, write dropped
        endcase
      end

      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      if (out_load) out_vld_q <= 1'b1;

      unique case (state_q)
        ST_IDLE:    if (in_acc && in_data_i.opcode == OP_LOAD) angle_q <= in_data_i.measured_angle;
        // predict
        ST_RATE:    rate_q  <= sat32(ext32(item_q.gyro_rate) - ext32(bias_q));
        ST_ANG_ADD: angle_q <= sat32(ext32(angle_q) + ext48(mres));
        ST_P00_ADD: begin
          p00_q <= sat48(ext48(p00_q) + ext48(mres));
          p01_q <= sat48(ext48(p01_q) - ext48(t_q));
          p10_q <= sat48(ext48(p10_q) - ext48(t_q));
        end
        ST_P11_ADD: p11_q   <= sat48(ext48(p11_q) + ext48(mres));
        // correct
        ST_KA_ADD:  angle_q <= sat32(ext32(angle_q) + ext48(mres));
        ST_KB_ADD:  bias_q  <= sat32(ext32(bias_q) + ext48(mres));
        ST_C00_ADD: p00_q   <= sat48(ext48(p00s_q) - ext48(mres));
        ST_C01_ADD: p01_q   <= sat48(ext48(p01s_q) - ext48(mres));
        ST_C10_ADD: p10_q   <= sat48(ext48(p10_q) - ext48(mres));
        ST_C11_ADD: p11_q   <= sat48(ext48(p11_q) - ext48(mres));
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    if (state_q == ST_INNER) begin
      t_q     <= mres;
      inner_q <= sat48(ext48(mres) - ext48(p01_q) - ext48(p10_q) + qa52);
    end
    if (state_q == ST_INNOV) begin
      // innovation and its variance, both wide enough to never clip
      y_q    <= {item_q.measured_angle[31], item_q.measured_angle} - {angle_q[31], angle_q};
      s_q    <= {p00_q[47], p00_q} + {9'b0, rm_q, 8'b0};
      p00s_q <= p00_q;
      p01s_q <= p01_q;
    end
    if (state_q == ST_DIV0 && div_done) k0_q <= dres;
    if (state_q == ST_DIV1 && div_done) k1_q <= dres;
    if (out_load) out_q <= '{angle_estimate: angle_q, unbiased_rate: rate_q};
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== src/abkf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_mul
// shared multiplier: 48x16 digit per cycle, then round and saturate
// ----------------------------------------------------------------------------
module abkf_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  abkf_pkg::mul_cmd_t  cmd_i,
  output logic                done_o,
  output logic signed [47:0]  res_o
);
  import abkf_pkg::*;

  logic [47:0]        ma_q, mb_q;
  logic               neg_q, wide_q;
  shift_e             sh_q;
  logic [95:0]        acc_q;
  logic [1:0]         cnt_q;
  logic               busy_q, rnd_q, done_q;
  logic signed [47:0] res_q;

  logic [48:0]  abs_a, abs_b;
  logic [15:0]  digit;
  logic [63:0]  pp;
  logic [96:0]  rsum, rshift, lim, clip;
  logic [47:0]  mag;

  assign abs_a = cmd_i.a[48] ? 49'(-cmd_i.a) : cmd_i.a;
  assign abs_b = cmd_i.b[48] ? 49'(-cmd_i.b) : cmd_i.b;
  assign digit = mb_q[cnt_q*16 +: 16];
  assign pp    = {16'b0, ma_q} * {48'b0, digit};

  // round half away from zero on the magnitude, then clip
  always_comb begin
    unique case (sh_q)
      SHIFT_16: begin
        rsum   = {1'b0, acc_q} + (97'd1 << 15);
        rshift = rsum >> 16;
      end
      SHIFT_24: begin
        rsum   = {1'b0, acc_q} + (97'd1 << 23);
        rshift = rsum >> 24;
      end
      default: begin
        rsum   = {1'b0, acc_q} + (97'd1 << 31);
        rshift = rsum >> 32;
      end
    endcase
    lim  = (wide_q ? (97'd1 << 47) : (97'd1 << 31)) - (neg_q ? 97'd0 : 97'd1);
    clip = (rshift > lim) ? lim : rshift;
    mag  = clip[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= rnd_q;
      rnd_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd2;
      end else if (busy_q) begin
        if (cnt_q == 2'd0) begin
          busy_q <= 1'b0;
          rnd_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= abs_a[47:0];
      mb_q   <= abs_b[47:0];
      neg_q  <= cmd_i.a[48] ^ cmd_i.b[48];
      sh_q   <= cmd_i.shift;
      wide_q <= cmd_i.wide;
      acc_q  <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[79:0], 16'b0} + {32'b0, pp};
    end
    if (rnd_q) begin
      res_q <= neg_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/abkf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_div
// restoring divider for the gains: (num << 32) / den saturated to 48 bits, 0 for den 0, one bit per cycle
// ----------------------------------------------------------------------------
module abkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic signed [48:0] den_i,
  output logic               done_o,
  output logic signed [47:0] res_o
);
  import abkf_pkg::*;

  localparam logic [79:0] Cap = 80'd1 << 47;

  logic [48:0]        md_q;
  logic [79:0]        dv_q, q_q;
  logic [48:0]        rem_q;
  logic [6:0]         cnt_q;
  logic               neg_q, busy_q, fin_q, done_q;
  logic signed [47:0] res_q;

  logic [48:0] abs_n, abs_d;
  logic [49:0] r2;
  logic        ge;
  logic [79:0] qc;

  assign abs_n = num_i[47] ? 49'(-ext48(num_i)) : {1'b0, num_i};
  assign abs_d = den_i[48] ? 49'(-den_i) : den_i;
  assign r2    = {rem_q, dv_q[79]};
  assign ge    = r2 >= {1'b0, md_q};

  always_comb begin
    qc = (q_q > Cap) ? Cap : q_q;
    if (!neg_q && qc > Cap - 80'd1) qc = Cap - 80'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q  <= 1'b0;
      done_q <= fin_q || (start_i && den_i == '0);
      if (start_i) begin
        busy_q <= den_i != '0;
        cnt_q  <= 7'd79;
      end else if (busy_q) begin
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      md_q  <= abs_d;
      neg_q <= num_i[47] ^ den_i[48];
      dv_q  <= {abs_n[47:0], 32'b0};
      rem_q <= '0;
      q_q   <= '0;
      if (den_i == '0) res_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 49'(r2 - {1'b0, md_q}) : r2[48:0];
      q_q   <= {q_q[78:0], ge};
      dv_q  <= {dv_q[78:0], 1'b0};
    end
    if (fin_q) begin
      res_q <= neg_q ? -$signed(qc[47:0]) : $signed(qc[47:0]);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/abkf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_checker
// port-level checks of the kalman filter, bound to the top level
// ----------------------------------------------------------------------------
module abkf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input abkf_pkg::abkf_out_t out_data_o
);
  import abkf_pkg::*;

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // a fresh result comes with the block free again
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while block still busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (.*);
